// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared assertion wrappers for the vertex cache miss counter. Both macros
// expand to nothing when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Checked on every rising edge of clk while reset is released.
`define FVC_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("fvcmc: assertion failed");
// Checked on every rising edge of clk, reset or not.
`define FVC_ASSERT_ALWAYS(lbl, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("fvcmc: assertion failed");
`else
`define FVC_ASSERT(lbl, prop)
`define FVC_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

// ----- rtl/core/fvcmc_pkg.sv -----
// ----------------------------------------------------------------------------
// fvcmc_pkg
// Types and constants shared by the vertex cache miss counter modules.
// ----------------------------------------------------------------------------
`default_nettype none

package fvcmc_pkg;

	localparam int CACHE_DEPTH_DEF = 64;
	localparam int INDEX_BITS_DEF  = 32;

	localparam int KEY_W   = 32;
	localparam int COUNT_W = 32;
	localparam int CAP_W   = 7;

	localparam int BASE_CACHE_SIZE = 35;
	localparam int RESERVED_SLOTS  = 3;

	localparam logic [CAP_W-1:0]   CAP_RESET = CAP_W'(BASE_CACHE_SIZE - RESERVED_SLOTS);
	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	// Per-cycle control broadcast to every cell of the chain.
	typedef struct packed {
		logic clear;  // current item empties the cache before its lookup
		logic shift;  // current item is an accepted miss: shift the chain
	} ctl_t;

endpackage

`default_nettype wire

// ----- rtl/core/fvcmc_cell.sv -----
// ----------------------------------------------------------------------------
// fvcmc_cell
// One cache slot: holds an entry and its occupied flag, compares the entry
// against the lookup key and takes its newer neighbor's contents on a miss.
// ----------------------------------------------------------------------------
`default_nettype none

module fvcmc_cell import fvcmc_pkg::*; #(
	parameter int POS         = 0,
	parameter int INDEX_BITS  = INDEX_BITS_DEF,
	parameter int CACHE_DEPTH = CACHE_DEPTH_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire ctl_t                  ctl,
	input  wire logic [CAP_W-1:0]      cap,
	input  wire logic [INDEX_BITS-1:0] key,
	input  wire logic [INDEX_BITS-1:0] prev_entry,
	input  wire logic                  prev_valid,
	output logic      [INDEX_BITS-1:0] entry,
	output logic                       valid,
	output logic                       match
);

	localparam int PW = ((CAP_W > $clog2(CACHE_DEPTH)) ? CAP_W : $clog2(CACHE_DEPTH)) + 1;

	logic [INDEX_BITS-1:0] entry_q;
	logic                  valid_q;
	logic                  keep;
	logic                  in_valid;

	// A slot past the configured capacity never stays occupied after a shift.
	assign keep     = PW'(POS) < PW'(cap);
	assign in_valid = (POS == 0) ? 1'b1 : (prev_valid & ~ctl.clear);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.shift) begin
			valid_q <= in_valid & keep;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			entry_q <= prev_entry;
		end
	end

	assign entry = entry_q;
	assign valid = valid_q;
	assign match = valid_q & ~ctl.clear & (entry_q == key);

endmodule

`default_nettype wire

// ----- rtl/core/fvcmc_chain.sv -----
// ----------------------------------------------------------------------------
// fvcmc_chain
// Row of cache cells, newest entry in cell 0, with the hit reduction.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module fvcmc_chain import fvcmc_pkg::*; #(
	parameter int INDEX_BITS  = INDEX_BITS_DEF,
	parameter int CACHE_DEPTH = CACHE_DEPTH_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire ctl_t                  ctl,
	input  wire logic [CAP_W-1:0]      cap,
	input  wire logic [INDEX_BITS-1:0] key,
	output logic                       hit
);

	logic [INDEX_BITS-1:0]  ent [CACHE_DEPTH];
	logic [CACHE_DEPTH-1:0] vld;
	logic [CACHE_DEPTH-1:0] vld_inc;
	logic [CACHE_DEPTH-1:0] mat;

	for (genvar i = 0; i < CACHE_DEPTH; i++) begin : g_cell
		fvcmc_cell #(
			.POS         (i),
			.INDEX_BITS  (INDEX_BITS),
			.CACHE_DEPTH (CACHE_DEPTH)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.cap        (cap),
			.key        (key),
			.prev_entry ((i == 0) ? key : ent[(i == 0) ? 0 : i - 1]),
			.prev_valid ((i == 0) ? 1'b1 : vld[(i == 0) ? 0 : i - 1]),
			.entry      (ent[i]),
			.valid      (vld[i]),
			.match      (mat[i])
		);
	end

	assign hit     = |mat;
	assign vld_inc = vld + CACHE_DEPTH'(1);

	// Occupied cells always form one run starting at cell 0.
	`FVC_ASSERT(a_vld_thermo, ((vld & vld_inc) == '0))
	// A key is inserted only on a miss, so it sits in at most one cell.
	`FVC_ASSERT(a_match_unique, $onehot0(mat))
	// With a nonzero capacity the newest entry is occupied after a miss.
	`FVC_ASSERT(a_insert_kept, (ctl.shift && (cap != '0)) |=> vld[0])

endmodule

`default_nettype wire

// ----- rtl/core/fifo_vertex_cache_miss_counter.sv -----
// ----------------------------------------------------------------------------
// fifo_vertex_cache_miss_counter
// FIFO post-transform vertex cache with a saturating miss counter.
// ----------------------------------------------------------------------------
// The block takes one vertex index per transfer and returns one result per
// transfer: a hit flag and the running miss count including that index. It
// sustains one transfer per clock: the lookup compares the incoming index
// against every occupied cell of the chain in the same cycle it is accepted,
// and on a miss the whole chain shifts by one at that clock edge, so the next
// index already sees the updated cache. The result appears in the output
// register in the cycle after acceptance, and a new index is accepted whenever
// that register is empty or its result is being taken in the same cycle;
// the input stall follows a stalled, full output register. The newest entry
// lives in cell 0 and the oldest occupied entry at the end of the occupied
// run, so eviction of the oldest entries is just the loss of the occupied
// flag on cells at or beyond the capacity. The capacity register is written
// through its own channel, which is always ready; values above the cache
// depth act as the depth, and zero makes every lookup a miss. Lowering the
// capacity evicts nothing until the next miss. Only the low INDEX_BITS bits
// of an index take part in the compare. There is no clearing pass after
// reset.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module fifo_vertex_cache_miss_counter import fvcmc_pkg::*; #(
	parameter int CACHE_DEPTH = CACHE_DEPTH_DEF,
	parameter int INDEX_BITS  = INDEX_BITS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// Index stream
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [KEY_W-1:0]   vertex_index,
	input  wire logic               clear_first,
	// Results
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic                    hit,
	output logic      [COUNT_W-1:0] miss_total,
	// Capacity register write
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [CAP_W-1:0]   cfg_data
);

	logic                  acc;
	logic                  hit_w;
	ctl_t                  ctl;
	logic [INDEX_BITS-1:0] key;
	logic [CAP_W-1:0]      cap_q;
	logic [COUNT_W-1:0]    cnt_q;
	logic [COUNT_W-1:0]    cnt_base;
	logic [COUNT_W-1:0]    cnt_next;
	logic                  out_valid_q;
	logic                  hit_q;
	logic [COUNT_W-1:0]    miss_total_q;

	// An index is taken whenever the output register can accept its result.
	assign in_stall = out_valid_q & out_stall;
	assign acc      = in_valid & ~in_stall;
	assign key      = vertex_index[INDEX_BITS-1:0];

	assign ctl.clear = clear_first;
	assign ctl.shift = acc & ~hit_w;

	fvcmc_chain #(
		.INDEX_BITS  (INDEX_BITS),
		.CACHE_DEPTH (CACHE_DEPTH)
	) u_chain (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.cap    (cap_q),
		.key    (key),
		.hit    (hit_w)
	);

	// The capacity register accepts a write in every cycle.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_valid) begin
			cap_q <= cfg_data;
		end
	end

	// The clear flag zeroes the count before this item's miss is counted,
	// and the count holds once it reaches its maximum.
	always_comb begin
		cnt_base = clear_first ? '0 : cnt_q;
		cnt_next = cnt_base;
		if (!hit_w && (cnt_base != COUNT_MAX)) begin
			cnt_next = cnt_base + COUNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (acc) begin
				cnt_q       <= cnt_next;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			hit_q        <= hit_w;
			miss_total_q <= cnt_next;
		end
	end

	assign out_valid  = out_valid_q;
	assign hit        = hit_q;
	assign miss_total = miss_total_q;

	// A cleared cache cannot hit.
	`FVC_ASSERT(a_clear_misses, (acc && clear_first) |-> !hit_w)
	// A hit without a clear leaves the miss count alone.
	`FVC_ASSERT(a_hit_keeps_count, (acc && hit_w && !clear_first) |=> $stable(cnt_q))
	// Every accepted index yields a result in the next cycle.
	`FVC_ASSERT(a_result_follows, acc |=> (out_valid && (miss_total == cnt_q)))

endmodule

`default_nettype wire

// ----- verif/tb_fifo_vertex_cache_miss_counter.sv -----
// ----------------------------------------------------------------------------
// tb_fifo_vertex_cache_miss_counter
// Self-checking testbench for the FIFO vertex cache miss counter. A short
// directed sequence is followed by random mesh walks under several cache
// capacities. Every accepted index is run through a local copy of the cache,
// and each returned hit flag and miss total is checked against it in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_fifo_vertex_cache_miss_counter;
	import fvcmc_pkg::*;

	// The result is registered, so a quiet spell of SETTLE_CYCLES after the
	// last result is enough to call the block idle.
	localparam int SETTLE_CYCLES  = 4;
	// Cycles with no transfer on any channel before the run is declared hung.
	// This covers the long receiver hold-off and the longest random gaps.
	localparam int WATCHDOG_LIMIT = 2000;
	// Length of the receiver hold-off that forces the block to back up.
	localparam int LONG_HOLD      = 300;
	localparam int PHASE_ITEMS    = 175;

	localparam logic [KEY_W-1:0] INDEX_MASK = KEY_W'((64'd1 << INDEX_BITS_DEF) - 1);

	typedef struct packed {
		logic [KEY_W-1:0] vertex_index;
		logic             clear_first;
	} vertex_item_t;

	typedef struct packed {
		logic               hit;
		logic [COUNT_W-1:0] miss_total;
	} lookup_result_t;

	logic               clk          = 1'b0;
	logic               arst_n       = 1'b0;
	logic               in_valid     = 1'b0;
	logic               in_stall;
	logic [KEY_W-1:0]   vertex_index = '0;
	logic               clear_first  = 1'b0;
	logic               out_valid;
	logic               out_stall    = 1'b0;
	logic               hit;
	logic [COUNT_W-1:0] miss_total;
	logic               cfg_valid    = 1'b0;
	logic               cfg_ready;
	logic [CAP_W-1:0]   cfg_data     = '0;

	fifo_vertex_cache_miss_counter uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.vertex_index (vertex_index),
		.clear_first  (clear_first),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.hit          (hit),
		.miss_total   (miss_total),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// Pending indices waiting for the driver, and lookups whose results have
	// not come back yet.
	vertex_item_t   pending_vertices[$];
	lookup_result_t expected_lookups[$];
	int             error_count = 0;

	// Set by the monitor at each rising edge: the index on the bus was taken.
	bit in_taken = 1'b0;
	// When set, the sender offers items back to back with no gaps.
	bit tx_dense = 1'b0;
	// The main sequence bumps this to ask the receiver for a long hold-off.
	int hold_requests = 0;

	// ------------------------------------------------------------------------
	// Local copy of the cache. Entry 0 is the oldest occupied entry, and only
	// the first cached_count entries are ever compared.
	// ------------------------------------------------------------------------
	logic [KEY_W-1:0]   cached_keys[CACHE_DEPTH_DEF];
	int                 cached_count   = 0;
	logic [COUNT_W-1:0] running_misses = '0;
	logic [CAP_W-1:0]   capacity_reg   = CAP_RESET;

	// Looks one index up, updates the local cache and returns what the block
	// should report for it.
	function automatic lookup_result_t cache_lookup(input vertex_item_t item);
		lookup_result_t res;
		logic [KEY_W-1:0] key;
		int i;
		int cap;
		int total;
		int drop;
		bit found;
		key = item.vertex_index & INDEX_MASK;
		// A clear takes effect before the lookup of the same item.
		if (item.clear_first) begin
			cached_count   = 0;
			running_misses = '0;
		end
		found = 1'b0;
		for (i = 0; i < cached_count; i++) begin
			if (cached_keys[i] == key)
				found = 1'b1;
		end
		// Hits leave the cache alone, even when the capacity was lowered
		// below the current occupancy. Only a miss trims the cache.
		if (!found) begin
			cap   = (int'(capacity_reg) > CACHE_DEPTH_DEF) ? CACHE_DEPTH_DEF
			                                               : int'(capacity_reg);
			total = cached_count + 1;
			drop  = (total > cap) ? total - cap : 0;
			if (running_misses != COUNT_MAX)
				running_misses = running_misses + 1'b1;
			if (drop >= total) begin
				// A capacity of zero keeps nothing at all.
				cached_count = 0;
			end else begin
				for (i = 0; i < cached_count - drop; i++)
					cached_keys[i] = cached_keys[i + drop];
				cached_count -= drop;
				if (cached_count < CACHE_DEPTH_DEF) begin
					cached_keys[cached_count] = key;
					cached_count++;
				end
			end
		end
		res.hit        = found;
		res.miss_total = running_misses;
		return res;
	endfunction

	// Idle cycles the sender leaves after a transfer: none when tx_dense is set,
	// else mostly none or a few, now and then a long one.
	function automatic int sender_gap();
		int r;
		r = $urandom_range(0, 99);
		if (tx_dense)
			return 0;
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// ------------------------------------------------------------------------
	// Driver. Inputs change on the falling edge. An offered index stays on the
	// bus, unchanged, until the monitor has seen it taken. When the next item
	// follows with no gap, in_valid simply stays high.
	// ------------------------------------------------------------------------
	int gap_left = 0;

	always @(negedge clk) begin
		vertex_item_t nxt;
		if (arst_n && !(in_valid && !in_taken)) begin
			if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (pending_vertices.size() != 0) begin
				nxt = pending_vertices[0];
				pending_vertices.delete(0);
				vertex_index <= nxt.vertex_index;
				clear_first  <= nxt.clear_first;
				in_valid     <= 1'b1;
				gap_left     = sender_gap();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Receiver. It alternates runs with no stall and stall bursts of random
	// length, with an occasional long stretch free of stalls. A hold-off
	// request from the main sequence overrides all of that for the long
	// hold-off, counted here.
	// ------------------------------------------------------------------------
	int holds_served = 0;
	int hold_left    = 0;
	int run_left     = 0;
	int stall_left   = 0;

	always @(negedge clk) begin
		int r;
		if (arst_n) begin
			if (hold_requests != holds_served) begin
				holds_served++;
				hold_left = LONG_HOLD - 1;
				out_stall <= 1'b1;
			end else if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else if (run_left > 0) begin
				run_left--;
				out_stall <= 1'b0;
			end else begin
				r = $urandom_range(0, 99);
				run_left = (r < 10) ? $urandom_range(100, 300) : $urandom_range(0, 15);
				r = $urandom_range(0, 99);
				if (r < 70)
					stall_left = $urandom_range(1, 2);
				else if (r < 92)
					stall_left = $urandom_range(3, 10);
				else
					stall_left = $urandom_range(20, 60);
				out_stall <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Monitor and watchdog. All channels are sampled at the rising edge. A
	// capacity write updates the local register, an accepted index is looked
	// up at once, and an accepted result is checked against the oldest
	// outstanding lookup.
	// ------------------------------------------------------------------------
	int quiet_cycles = 0;

	always @(posedge clk) begin
		vertex_item_t   seen;
		lookup_result_t predicted;
		lookup_result_t want;
		bit             out_taken;
		bit             cfg_taken;
		if (arst_n) begin
			in_taken  = in_valid && !in_stall;
			out_taken = out_valid && !out_stall;
			cfg_taken = cfg_valid && cfg_ready;
			if (cfg_taken)
				capacity_reg = cfg_data;
			if (in_taken) begin
				seen.vertex_index = vertex_index;
				seen.clear_first  = clear_first;
				predicted         = cache_lookup(seen);
				expected_lookups  = {expected_lookups, predicted};
			end
			if (out_taken) begin
				if (expected_lookups.size() == 0) begin
					$error("unexpected result transfer: hit=%0b miss_total=%0d",
						hit, miss_total);
					error_count++;
				end else begin
					want = expected_lookups[0];
					expected_lookups.delete(0);
					if (hit !== want.hit) begin
						$error("hit: expected %0b, actual %0b", want.hit, hit);
						error_count++;
					end
					if (miss_total !== want.miss_total) begin
						$error("miss_total: expected %0d, actual %0d",
							want.miss_total, miss_total);
						error_count++;
					end
				end
			end
			// The watchdog restarts on any transfer on any channel.
			if (in_taken || out_taken || cfg_taken)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog expired after %0d cycles without a transfer",
					quiet_cycles);
				$display("** fifo_vertex_cache_miss_counter: FAILED **");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus helpers.
	// ------------------------------------------------------------------------
	task automatic queue_vertex(input logic [KEY_W-1:0] idx, input logic clr);
		vertex_item_t item;
		item.vertex_index = idx;
		item.clear_first  = clr;
		pending_vertices  = {pending_vertices, item};
	endtask

	// Waits until every queued index has been taken and every result has come
	// back, then lets the result path settle. The check runs on the rising
	// edge, where the driver never touches the queue or in_valid.
	task automatic wait_idle();
		while (pending_vertices.size() != 0 || in_valid || expected_lookups.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_capacity(input logic [CAP_W-1:0] value);
		@(negedge clk);
		cfg_data  <= value;
		cfg_valid <= 1'b1;
		do
			@(posedge clk);
		while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Random indices shaped like a walk over a triangle mesh: most indices
	// fall in a small window around a base that creeps forward, so they hit
	// the cache often, and the base sometimes jumps to a new mesh. The rest
	// are fully random indices, the two extreme indices and rare clears.
	task automatic queue_mesh_walk(input int count, input int cap);
		int window;
		int i;
		int r;
		logic [KEY_W-1:0] base;
		logic [KEY_W-1:0] idx;
		window = ((cap > CACHE_DEPTH_DEF) ? CACHE_DEPTH_DEF : cap) * 2 + 2;
		base   = $urandom();
		for (i = 0; i < count; i++) begin
			r = $urandom_range(0, 99);
			if (r < 4)
				base = $urandom();
			else if (r < 20)
				base = base + $urandom_range(1, window / 2 + 1);
			r = $urandom_range(0, 99);
			if (r < 85)
				idx = base + $urandom_range(0, window);
			else if (r < 95)
				idx = $urandom();
			else if (r < 97)
				idx = '0;
			else if (r < 99)
				idx = '1;
			else
				idx = base;
			queue_vertex(idx, $urandom_range(0, 49) == 0);
		end
	endtask

	// One random phase: wait for the block to drain, set the capacity, the sender
	// mode and any hold-off request, then queue a mesh walk. The cache state
	// carries over, so a change of capacity can act on a cache that holds entries.
	task automatic run_phase(input int cap, input bit dense, input bit pressure);
		wait_idle();
		write_capacity(CAP_W'(cap));
		tx_dense = dense;
		if (pressure)
			hold_requests++;
		queue_mesh_walk(PHASE_ITEMS, cap);
	endtask

	// ------------------------------------------------------------------------
	// Main sequence.
	// ------------------------------------------------------------------------
	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part at the reset capacity: extreme indices, repeats that
		// must hit, and a clear that forgets everything before its lookup.
		queue_vertex(32'h0000_0000, 1'b0);
		queue_vertex(32'hFFFF_FFFF, 1'b0);
		queue_vertex(32'h0000_0000, 1'b0);
		queue_vertex(32'hFFFF_FFFF, 1'b0);
		queue_vertex(32'h8000_0000, 1'b0);
		queue_vertex(32'h7FFF_FFFF, 1'b0);
		queue_vertex(32'h8000_0000, 1'b0);
		queue_vertex(32'h1234_5678, 1'b1);
		queue_vertex(32'h0000_0000, 1'b0);
		queue_vertex(32'h1234_5678, 1'b0);

		// A single entry: a repeat hits, a new index evicts the old one.
		wait_idle();
		write_capacity(CAP_W'(1));
		queue_vertex(32'd5, 1'b0);
		queue_vertex(32'd5, 1'b0);
		queue_vertex(32'd6, 1'b0);
		queue_vertex(32'd5, 1'b0);

		// Capacity zero: nothing is kept, so even a repeat misses.
		wait_idle();
		write_capacity(CAP_W'(0));
		queue_vertex(32'd7, 1'b0);
		queue_vertex(32'd7, 1'b0);

		// Fill a few entries, then lower the capacity below the occupancy.
		// The oldest entries still hit until the next miss trims the cache.
		wait_idle();
		write_capacity(CAP_W'(CACHE_DEPTH_DEF));
		queue_vertex(32'd100, 1'b0);
		queue_vertex(32'd101, 1'b0);
		queue_vertex(32'd102, 1'b0);
		queue_vertex(32'd103, 1'b0);
		queue_vertex(32'd104, 1'b0);
		wait_idle();
		write_capacity(CAP_W'(2));
		queue_vertex(32'd100, 1'b0);
		queue_vertex(32'd104, 1'b0);
		queue_vertex(32'd200, 1'b0);
		queue_vertex(32'd100, 1'b0);

		// Random phases. The largest register value acts as the full depth.
		// The phase at capacity 100 holds the receiver off while the sender
		// keeps offering, so the block backs up and stalls its input.
		run_phase(127, 1'b0, 1'b0);
		run_phase(CACHE_DEPTH_DEF, 1'b0, 1'b0);
		run_phase(3, 1'b0, 1'b0);
		run_phase(100, 1'b1, 1'b1);
		run_phase(1, 1'b0, 1'b0);
		run_phase(0, 1'b0, 1'b0);
		run_phase(65, 1'b0, 1'b0);
		run_phase(int'(CAP_RESET), 1'b1, 1'b0);
		run_phase($urandom_range(2, 63), 1'b0, 1'b0);
		run_phase($urandom_range(0, 127), 1'b0, 1'b0);

		wait_idle();
		if (error_count == 0) begin
			$display("** fifo_vertex_cache_miss_counter: PASSED **");
		end else begin
			$display("** fifo_vertex_cache_miss_counter: FAILED **");
		end
		$finish;
	end

endmodule

`default_nettype wire

// ----- sim.f -----
+incdir+rtl/core
rtl/core/fvcmc_pkg.sv
rtl/core/fvcmc_cell.sv
rtl/core/fvcmc_chain.sv
rtl/core/fifo_vertex_cache_miss_counter.sv
verif/tb_fifo_vertex_cache_miss_counter.sv
